// ===== rtl/kfq_pkg.sv =====
// shared types, codes and defaults of the keyframe-aware packet queue
package kfq_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int ID_W            = 16;
	localparam int OCC_W           = 7;
	localparam int MAXP_W          = 6;
	localparam logic [MAXP_W-1:0] MAXP_RESET = 6'd32;

	// key flag sits in the lowest bit of a stored entry, handle above it
	localparam int KEY_BIT = 0;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		KIND_EMPTY   = 2'd0,
		KIND_POPPED  = 2'd1,
		KIND_DROPPED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_RAM  = 2'd1,
		SRC_CUR  = 2'd2
	} src_t;

	typedef enum logic [1:0] {
		RD_HEAD  = 2'd0,
		RD_NEXT  = 2'd1,
		RD_AFTER = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    push_wr;
		logic    emit;
		kind_t   kind;
		src_t    src;
		logic    last;
		logic    take;
		logic    load_cur;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic over_limit;
		logic front_key;
		logic walk_fin;
	} status_t;

endpackage

// ===== rtl/kfq_ram.sv =====
// generic single-write, single-read ram with registered read data
module kfq_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/kfq_datapath.sv =====
// queue pointers, entry storage, limit register and result registers
module kfq_datapath #(
	parameter int DEPTH       = kfq_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = kfq_pkg::HANDLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kfq_pkg::cmd_t               cmd,
	output kfq_pkg::status_t            status,
	input  logic [kfq_pkg::ID_W-1:0]    packet_id,
	input  logic                        is_key,
	input  logic                        cfg_valid,
	input  logic [kfq_pkg::MAXP_W-1:0]  cfg_data,
	output logic                        out_valid,
	output logic [1:0]                  kind,
	output logic [kfq_pkg::ID_W-1:0]    out_packet_id,
	output logic                        out_is_key,
	output logic                        last,
	output logic [kfq_pkg::OCC_W-1:0]   occupancy
);

	localparam int HW    = (HANDLE_BITS < kfq_pkg::ID_W) ? HANDLE_BITS : kfq_pkg::ID_W;
	localparam int EW    = HW + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = CW + kfq_pkg::MAXP_W;

	logic [AW-1:0]                 head_q;
	logic [CW-1:0]                 count_q;
	logic [kfq_pkg::MAXP_W-1:0]    maxp_q;
	logic [EW-1:0]                 cur_q;

	logic                          out_valid_q;
	kfq_pkg::kind_t                kind_q;
	logic [kfq_pkg::ID_W-1:0]      id_q;
	logic                          key_q;
	logic                          last_q;
	logic [kfq_pkg::OCC_W-1:0]     occ_q;

	logic [AW-1:0]  head_p1;
	logic [AW-1:0]  head_p2;
	logic [AW:0]    tail_sum;
	logic [AW-1:0]  tail;
	logic [AW-1:0]  raddr;
	logic [EW-1:0]  rd_data;
	logic [EW-1:0]  wr_data;
	logic [EW-1:0]  sel_entry;
	logic [CW-1:0]  count_nxt;
	logic [CMP_W-1:0] maxp_ext;
	logic [CMP_W-1:0] limit;

	// circular pointer arithmetic
	always_comb begin
		head_p1 = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
		head_p2 = (head_p1 == AW'(DEPTH - 1)) ? '0 : head_p1 + AW'(1);
		tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);
		tail = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
			: AW'(tail_sum);
	end

	always_comb begin
		case (cmd.rd_sel)
			kfq_pkg::RD_NEXT:  raddr = head_p1;
			kfq_pkg::RD_AFTER: raddr = head_p2;
			default:           raddr = head_q;
		endcase
	end

	assign wr_data = {packet_id[HW-1:0], is_key};

	kfq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push_wr),
		.waddr (tail),
		.wdata (wr_data),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// limit saturates to one below the storage depth
	always_comb begin
		maxp_ext = CMP_W'(maxp_q);
		limit = (maxp_ext > CMP_W'(DEPTH - 1)) ? CMP_W'(DEPTH - 1) : maxp_ext;
	end

	always_comb begin
		if (cmd.push_wr) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.take) begin
			count_nxt = count_q - CW'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	always_comb begin
		case (cmd.src)
			kfq_pkg::SRC_RAM: sel_entry = rd_data;
			kfq_pkg::SRC_CUR: sel_entry = cur_q;
			default:          sel_entry = '0;
		endcase
	end

	always_comb begin
		status.count_zero = (count_q == '0);
		status.over_limit = (CMP_W'(count_q) > limit);
		status.front_key  = rd_data[kfq_pkg::KEY_BIT];
		status.walk_fin   = (count_q == CW'(1)) || rd_data[kfq_pkg::KEY_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			maxp_q      <= kfq_pkg::MAXP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_nxt;
			out_valid_q <= cmd.emit;
			if (cmd.take) begin
				head_q <= head_p1;
			end
			if (cfg_valid) begin
				maxp_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cur) begin
			cur_q <= rd_data;
		end
		if (cmd.emit) begin
			kind_q <= cmd.kind;
			id_q   <= kfq_pkg::ID_W'(sel_entry[EW-1:1]);
			key_q  <= sel_entry[kfq_pkg::KEY_BIT];
			last_q <= cmd.last;
			occ_q  <= kfq_pkg::OCC_W'(count_nxt);
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign out_packet_id = id_q;
	assign out_is_key    = key_q;
	assign last          = last_q;
	assign occupancy     = occ_q;

endmodule

// ===== rtl/kfq_ctrl.sv =====
// sequencing state machine for push, pop and overflow drop walk
module kfq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  kfq_pkg::status_t  status,
	output kfq_pkg::cmd_t     cmd,
	output logic              busy
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_POP   = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_FRONT = 5'b01000,
		ST_WALK  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt    = state_q;
		cmd.push_wr  = 1'b0;
		cmd.emit     = 1'b0;
		cmd.kind     = kfq_pkg::KIND_EMPTY;
		cmd.src      = kfq_pkg::SRC_ZERO;
		cmd.last     = 1'b1;
		cmd.take     = 1'b0;
		cmd.load_cur = 1'b0;
		cmd.rd_sel   = kfq_pkg::RD_HEAD;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (operation == kfq_pkg::OP_POP) begin
						if (status.count_zero) begin
							cmd.emit = 1'b1;
						end else begin
							state_nxt = ST_POP;
						end
					end else begin
						cmd.push_wr = 1'b1;
						state_nxt   = ST_CHECK;
					end
				end
			end
			ST_POP: begin
				cmd.emit  = 1'b1;
				cmd.kind  = kfq_pkg::KIND_POPPED;
				cmd.src   = kfq_pkg::SRC_RAM;
				cmd.take  = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_CHECK: begin
				state_nxt = status.over_limit ? ST_FRONT : ST_IDLE;
			end
			ST_FRONT: begin
				if (status.front_key) begin
					cmd.emit  = 1'b1;
					cmd.kind  = kfq_pkg::KIND_DROPPED;
					cmd.src   = kfq_pkg::SRC_RAM;
					cmd.take  = 1'b1;
					state_nxt = ST_IDLE;
				end else begin
					cmd.load_cur = 1'b1;
					cmd.rd_sel   = kfq_pkg::RD_NEXT;
					state_nxt    = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.emit     = 1'b1;
				cmd.kind     = kfq_pkg::KIND_DROPPED;
				cmd.src      = kfq_pkg::SRC_CUR;
				cmd.last     = status.walk_fin;
				cmd.take     = 1'b1;
				cmd.load_cur = 1'b1;
				cmd.rd_sel   = kfq_pkg::RD_AFTER;
				if (status.walk_fin) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/keyframe_aware_packet_fifo_core.sv =====
// top level of the keyframe-aware bounded packet queue
//
// channel   direction  handshake                 payload
// request   in         start & !busy             operation, packet_id, is_key
// result    out        out_valid (one cycle)     kind, out_packet_id, out_is_key, last,
//                                                occupancy
// config    in         cfg_valid & cfg_ready     cfg_data (max_packets)
//
// push without overflow: accept with ram write, then limit check
// pop: on an empty queue the empty result is formed at acceptance, otherwise after a registered ram read
// overflow push: accept, limit check, then a key frame at the front is dropped alone, otherwise
// a walk drops the front entries one by one; the ram read port fetches one entry ahead
// so the walk drops one entry a cycle
// results leave through an output register in the cycle after they are formed and
// cannot be held off; no clearing pass after reset, the queue is usable at once
module keyframe_aware_packet_fifo_core #(
	parameter int DEPTH       = kfq_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = kfq_pkg::HANDLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [kfq_pkg::ID_W-1:0]    packet_id,
	input  logic                        is_key,
	// limit register write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kfq_pkg::MAXP_W-1:0]  cfg_data,
	// result channel
	output logic                        out_valid,
	output logic [1:0]                  kind,
	output logic [kfq_pkg::ID_W-1:0]    out_packet_id,
	output logic                        out_is_key,
	output logic                        last,
	output logic [kfq_pkg::OCC_W-1:0]   occupancy
);

	kfq_pkg::cmd_t    cmd;
	kfq_pkg::status_t status;
	logic             busy_int;

	// request accepted only while the controller sits idle
	kfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy_int)
	);

	// storage, pointers and result registers
	kfq_datapath #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.packet_id     (packet_id),
		.is_key        (is_key),
		.cfg_valid     (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.kind          (kind),
		.out_packet_id (out_packet_id),
		.out_is_key    (out_is_key),
		.last          (last),
		.occupancy     (occupancy)
	);

	assign busy = busy_int;

	// limit writes go straight into the limit register, only while idle
	assign cfg_ready = !busy_int;

endmodule
